FILE: hw/rtl/pcs_pkg.sv
// Shared types, register map and helpers for the pulse count selector.
`timescale 1ns / 1ps

package pcs_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_WINDOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_TO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_ON         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_GAP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_CYCLE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE          = 3'd5;

    localparam logic [15:0] RST_COUNT_WINDOW = 16'd1000;
    localparam logic [15:0] RST_FEEDBACK_TO  = 16'd5000;
    localparam logic [15:0] RST_BEEP_ON      = 16'd150;
    localparam logic [15:0] RST_BEEP_GAP     = 16'd50;
    localparam logic [15:0] RST_BEEP_CYCLE   = 16'd1500;
    localparam logic [15:0] RST_SETTLE       = 16'd1000;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_EDGE  = 2'd1,
        CMD_LEVEL = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_COUNT    = 2'd1,
        MODE_FEEDBACK = 2'd2,
        MODE_EXEC     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ON    = 2'd1,
        PH_GAP   = 2'd2,
        PH_WAIT  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_RESET_ALL    = 3'd1,
        ACT_ZONE2_TARGET = 3'd2,
        ACT_ZONE2_APPLY  = 3'd3,
        ACT_ZONE3_PREP   = 3'd4,
        ACT_ZONE3        = 3'd5
    } act_t;

    localparam logic [2:0] SEL_ZERO  = 3'd0;
    localparam logic [2:0] SEL_ONE   = 3'd1;
    localparam logic [2:0] SEL_TWO   = 3'd2;
    localparam logic [2:0] SEL_THREE = 3'd3;

    typedef struct packed {
        logic [15:0] quiet_ms;
        logic [15:0] confirm_ms;
        logic [15:0] chirp_ms;
        logic [15:0] space_ms;
        logic [15:0] period_ms;
        logic [15:0] settle_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_ms;
        logic        arm_level;
    } item_t;

    typedef struct packed {
        logic [15:0] beep_ms;
        logic        mute;
        act_t        action;
        logic        active;
        logic [2:0]  selection;
    } res_t;

    // 16 = 1 mod 5, so fold the nibbles, then strip multiples of five
    function automatic logic [2:0] mod5(input logic [7:0] x);
        logic [4:0] s;
        s = {1'b0, x[7:4]} + {1'b0, x[3:0]};
        if (s >= 5'd15) s = s - 5'd15;
        if (s >= 5'd10) s = s - 5'd10;
        if (s >= 5'd5)  s = s - 5'd5;
        return s[2:0];
    endfunction

endpackage

FILE: hw/rtl/pcs_if.sv
// Valid/ready channel interfaces for items, results and register writes.
`timescale 1ns / 1ps

interface pcs_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic        arm_level;

    modport source (output valid, output command, output now_ms, output arm_level,
                    input ready);
    modport sink   (input valid, input command, input now_ms, input arm_level,
                    output ready);
endinterface

interface pcs_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] beep_ms;
    logic        mute;
    logic [2:0]  action;
    logic        active;
    logic [2:0]  selection;

    modport source (output valid, output beep_ms, output mute, output action,
                    output active, output selection, input ready);
    modport sink   (input valid, input beep_ms, input mute, input action,
                    input active, input selection, output ready);
endinterface

interface pcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/pulse_count_selector_with_beeps.sv
// Top level: channel registers, register file and the selector core.
//
//   channel   dir   words
//   item      in    command, now_ms, arm_level
//   result    out   beep_ms, mute, action, active, selection
//   cfg       in    index, data (always ready)
//
// One item per cycle while the result is taken: an item is registered, stepped
// through the core and lands in the result register.
// The result register stalls the step; the input register then holds one word.
// rst_n clears all control state and loads the register defaults.
`timescale 1ns / 1ps

module pulse_count_selector_with_beeps (
    input  logic         clk,
    input  logic         rst_n,
    pcs_item_if.sink     item,
    pcs_result_if.source result,
    pcs_cfg_if.sink      cfg
);
    import pcs_pkg::*;

    item_t item_reg;
    logic  in_vld_reg;
    res_t  res_reg;
    logic  res_vld_reg;
    cfg_t  cfg_reg;
    res_t  step_res;
    logic  step_en;
    logic  item_take;

    assign step_en   = in_vld_reg && (!res_vld_reg || result.ready);
    assign item.ready = !in_vld_reg || step_en;
    assign item_take = item.valid && item.ready;
    assign cfg.ready = 1'b1;

    pcs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (step_en),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
                in_vld_reg <= 1'b1;
            else if (step_en)
                in_vld_reg <= 1'b0;

            if (step_en)
                res_vld_reg <= 1'b1;
            else if (result.ready)
                res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg.command   <= item.command;
            item_reg.now_ms    <= item.now_ms;
            item_reg.arm_level <= item.arm_level;
        end
        if (step_en)
            res_reg <= step_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quiet_ms   <= RST_COUNT_WINDOW;
            cfg_reg.confirm_ms <= RST_FEEDBACK_TO;
            cfg_reg.chirp_ms   <= RST_BEEP_ON;
            cfg_reg.space_ms   <= RST_BEEP_GAP;
            cfg_reg.period_ms  <= RST_BEEP_CYCLE;
            cfg_reg.settle_ms  <= RST_SETTLE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_COUNT_WINDOW: cfg_reg.quiet_ms   <= cfg.data;
                REG_FEEDBACK_TO:  cfg_reg.confirm_ms <= cfg.data;
                REG_BEEP_ON:      cfg_reg.chirp_ms   <= cfg.data;
                REG_BEEP_GAP:     cfg_reg.space_ms   <= cfg.data;
                REG_BEEP_CYCLE:   cfg_reg.period_ms  <= cfg.data;
                REG_SETTLE:       cfg_reg.settle_ms  <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    assign result.valid      = res_vld_reg;
    assign result.beep_ms    = res_reg.beep_ms;
    assign result.mute       = res_reg.mute;
    assign result.action     = res_reg.action;
    assign result.active     = res_reg.active;
    assign result.selection  = res_reg.selection;

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> in_vld_reg)
        else $error("input stalled with empty input register");

    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> res_vld_reg)
        else $error("stepped word did not reach the result register");

    a_silence_drops_tone: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.mute |-> res_reg.beep_ms == 16'd0)
        else $error("tone reported together with silence");

    a_selection_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> res_reg.selection < 3'd5)
        else $error("selection out of range");

endmodule

FILE: hw/rtl/pcs_core.sv
// Selector state registers and the single-pass step logic for one item.
`timescale 1ns / 1ps

module pcs_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  pcs_pkg::item_t item,
    input  pcs_pkg::cfg_t  cfg,
    output pcs_pkg::res_t  res
);
    import pcs_pkg::*;

    mode_t       mode_reg,   mode_next;
    logic [7:0]  count_reg,  count_next;
    logic        arm_low_reg, arm_low_next;
    logic [31:0] win_reg,    win_next;
    logic        xstep_reg,  xstep_next;
    logic [31:0] xstart_reg, xstart_next;
    logic [31:0] cstart_reg, cstart_next;
    logic [31:0] mark_reg,   mark_next;
    phase_t      phase_reg,  phase_next;
    logic [2:0]  idx_reg,    idx_next;
    logic        long_reg,   long_next;

    logic [2:0]  sel_cur;
    logic [31:0] now;

    assign sel_cur = mod5(count_reg);
    assign now     = item.now_ms;

    always_comb
    begin
        logic [15:0] o_beep;
        logic        o_off;
        act_t        o_act;
        logic        run_pattern;

        mode_next    = mode_reg;
        count_next   = count_reg;
        arm_low_next = arm_low_reg;
        win_next     = win_reg;
        xstep_next   = xstep_reg;
        xstart_next  = xstart_reg;
        cstart_next  = cstart_reg;
        mark_next    = mark_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        long_next    = long_reg;
        o_beep       = '0;
        o_off        = 1'b0;
        o_act        = ACT_NONE;
        run_pattern  = 1'b0;

        unique case (item.command)
            CMD_TICK:
            begin
                if (mode_next == MODE_COUNT && (now - win_next) >= {16'd0, cfg.quiet_ms})
                begin
                    // counting window closed: start the feedback pattern
                    mode_next   = MODE_FEEDBACK;
                    win_next    = now;
                    o_off       = 1'b1;
                    o_beep      = '0;
                    phase_next  = PH_START;
                    idx_next    = '0;
                    long_next   = 1'b0;
                    cstart_next = now;
                    mark_next   = now;
                    if (sel_cur == SEL_ZERO)
                    begin
                        long_next = 1'b1;
                        o_beep    = cfg.period_ms;
                        o_off     = 1'b0;
                    end
                end
                if (mode_next == MODE_FEEDBACK)
                begin
                    if ((now - win_next) >= {16'd0, cfg.confirm_ms})
                    begin
                        o_off      = 1'b1;
                        o_beep     = '0;
                        phase_next = PH_START;
                        idx_next   = '0;
                        long_next  = 1'b0;
                        mode_next  = MODE_IDLE;
                        count_next = '0;
                    end
                    else
                    begin
                        run_pattern = 1'b1;
                    end
                end
                if (mode_next == MODE_EXEC)
                    run_pattern = 1'b1;

                if (run_pattern)
                begin
                    if (long_next)
                    begin
                        if ((now - mark_next) >= {16'd0, cfg.period_ms})
                        begin
                            mark_next = now;
                            o_beep    = cfg.period_ms;
                            o_off     = 1'b0;
                        end
                    end
                    else if (sel_cur != SEL_ZERO)
                    begin
                        case (phase_next)
                            PH_START:
                            begin
                                o_beep     = cfg.chirp_ms;
                                o_off      = 1'b0;
                                phase_next = PH_ON;
                                mark_next  = now;
                            end
                            PH_ON:
                            begin
                                if ((now - mark_next) >= {16'd0, cfg.chirp_ms})
                                begin
                                    idx_next   = idx_next + 3'd1;
                                    phase_next = (idx_next >= sel_cur) ? PH_WAIT : PH_GAP;
                                    mark_next  = now;
                                end
                            end
                            PH_GAP:
                            begin
                                if ((now - mark_next) >= {16'd0, cfg.space_ms})
                                    phase_next = PH_START;
                            end
                            default:
                            begin
                                if ((now - cstart_next) >= {16'd0, cfg.period_ms})
                                begin
                                    cstart_next = now;
                                    idx_next    = '0;
                                    phase_next  = PH_START;
                                end
                            end
                        endcase
                    end
                end

                if (mode_next == MODE_EXEC)
                begin
                    if (!xstep_next)
                    begin
                        if (sel_cur == SEL_TWO)
                        begin
                            o_act       = ACT_ZONE2_TARGET;
                            xstep_next  = 1'b1;
                            xstart_next = now;
                        end
                        else
                        begin
                            o_act      = (sel_cur == SEL_THREE) ? ACT_ZONE3_PREP : ACT_ZONE3;
                            o_off      = 1'b1;
                            o_beep     = '0;
                            phase_next = PH_START;
                            idx_next   = '0;
                            long_next  = 1'b0;
                            mode_next  = MODE_IDLE;
                        end
                    end
                    else if ((now - xstart_next) >= {16'd0, cfg.settle_ms})
                    begin
                        if (sel_cur == SEL_TWO)
                            o_act = ACT_ZONE2_APPLY;
                        o_off      = 1'b1;
                        o_beep     = '0;
                        phase_next = PH_START;
                        idx_next   = '0;
                        long_next  = 1'b0;
                        mode_next  = MODE_IDLE;
                    end
                end
            end
            CMD_EDGE:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    if (arm_low_reg)
                    begin
                        mode_next  = MODE_COUNT;
                        win_next   = now;
                        count_next = 8'd1;
                        o_beep     = cfg.chirp_ms;
                    end
                end
                else if (mode_reg == MODE_COUNT)
                begin
                    if (!arm_low_reg)
                    begin
                        o_off      = 1'b1;
                        phase_next = PH_START;
                        idx_next   = '0;
                        long_next  = 1'b0;
                        mode_next  = MODE_IDLE;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 8'd1;
                        win_next   = now;
                        o_beep     = cfg.chirp_ms;
                    end
                end
            end
            CMD_LEVEL:
            begin
                arm_low_next = !item.arm_level;
                if (!item.arm_level && mode_reg == MODE_IDLE)
                    o_act = ACT_RESET_ALL;
                if (mode_reg == MODE_FEEDBACK && item.arm_level)
                begin
                    o_off      = 1'b1;
                    phase_next = PH_START;
                    idx_next   = '0;
                    long_next  = 1'b0;
                    if (sel_cur == SEL_ZERO || sel_cur == SEL_ONE)
                    begin
                        mode_next  = MODE_IDLE;
                        count_next = '0;
                    end
                    else
                    begin
                        // confirmed: restart the pattern and run the action
                        mode_next   = MODE_EXEC;
                        xstep_next  = 1'b0;
                        xstart_next = now;
                        cstart_next = now;
                        mark_next   = now;
                    end
                end
                else if (!item.arm_level &&
                         (mode_reg == MODE_COUNT || mode_reg == MODE_FEEDBACK))
                begin
                    o_off      = 1'b1;
                    phase_next = PH_START;
                    idx_next   = '0;
                    long_next  = 1'b0;
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                end
            end
            default:
            begin
            end
        endcase

        if (o_off)
            o_beep = '0;

        res.beep_ms    = o_beep;
        res.mute       = o_off;
        res.action     = o_act;
        res.active     = (mode_next != MODE_IDLE);
        res.selection  = mod5(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            count_reg   <= '0;
            arm_low_reg <= 1'b0;
            win_reg     <= '0;
            xstep_reg   <= 1'b0;
            xstart_reg  <= '0;
            cstart_reg  <= '0;
            mark_reg    <= '0;
            phase_reg   <= PH_START;
            idx_reg     <= '0;
            long_reg    <= 1'b0;
        end
        else if (en)
        begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            arm_low_reg <= arm_low_next;
            win_reg     <= win_next;
            xstep_reg   <= xstep_next;
            xstart_reg  <= xstart_next;
            cstart_reg  <= cstart_next;
            mark_reg    <= mark_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            long_reg    <= long_next;
        end
    end

    a_exec_step_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        xstep_reg && !$past(xstep_reg) |-> mode_reg == MODE_EXEC)
        else $error("exec step set outside execution");

    a_long_tone_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        long_reg |-> mode_reg == MODE_FEEDBACK || mode_reg == MODE_EXEC)
        else $error("long tone flag left set outside feedback");

    a_count_nonzero_while_counting: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_COUNT && $past(mode_reg) == MODE_IDLE |-> count_reg == 8'd1)
        else $error("first edge did not set count to one");

endmodule
